@@ hdl/ies_pkg.sv @@
// Shared types and constants for the interrupt entry sequencer.
// Used by ies_ctrl, ies_emit and the interrupt_entry_sequencer top level.
package ies_pkg;

  // Command codes on the request channel
  typedef enum logic [1:0] {
    CMD_RAISE = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_REPLY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_t;

  // Sequence phase: which read reply the block waits for
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_GATE_HI = 3'd1,
    PH_GATE_LO = 3'd2,
    PH_GDT_LO  = 3'd3,
    PH_GDT_HI  = 3'd4,
    PH_KSP     = 3'd5
  } phase_t;

  // Steps of the push/finish burst
  typedef enum logic [2:0] {
    ST_PUSH_SS    = 3'd0,
    ST_PUSH_ESP   = 3'd1,
    ST_CLEAR_KSP  = 3'd2,
    ST_PUSH_FLAGS = 3'd3,
    ST_PUSH_CS    = 3'd4,
    ST_PUSH_RET   = 3'd5,
    ST_DONE       = 3'd6
  } step_t;

  // Configuration register indexes
  localparam logic [1:0] REG_IDT_BASE = 2'd0;
  localparam logic [1:0] REG_GDT_BASE = 2'd1;
  localparam logic [1:0] REG_TASK_IDX = 2'd2;

  localparam logic [7:0]  TIMER_VECTOR = 8'd32;
  localparam int          IF_BIT       = 9;
  localparam int          PRESENT_BIT  = 15;
  localparam logic [1:0]  USER_PL      = 2'b11;
  localparam logic [31:0] DWORD_BYTES  = 32'd4;

  // Work handed from the control stage to the result stage
  typedef struct packed {
    logic        seq;    // 1: push burst, 0: one single result
    step_t       start;  // first step of a push burst
    kind_t       kind;   // kind of a single result
    logic [31:0] addr;   // address of a single read
    logic [31:0] sp;     // stack pointer before the first push
  } burst_t;

  // Saved context the result stage reads while draining a burst
  typedef struct packed {
    logic [15:0] ss;
    logic [31:0] esp;
    logic [31:0] flags;
    logic [15:0] cs;
    logic [31:0] ret;
    logic [31:0] handler;
    logic [31:0] tss;
  } ctx_t;

endpackage

@@ hdl/ies_ctrl.sv @@
// Control stage: configuration registers, sequence phase and saved context.
// Decodes one request per cycle into a burst descriptor, advancing only on accept. Depends on ies_pkg.
module ies_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                accept,
  input  logic [1:0]          command,
  input  logic [7:0]          vector,
  input  logic [31:0]         return_addr,
  input  logic [15:0]         code_seg,
  input  logic [15:0]         stack_seg,
  input  logic [31:0]         stack_ptr,
  input  logic [31:0]         flags,
  input  logic                timer_pending,
  input  logic [31:0]         read_data,
  output ies_pkg::burst_t     burst,
  output ies_pkg::ctx_t       ctx
);
  import ies_pkg::*;

  logic [31:0] idt_base;
  logic [31:0] gdt_base;
  logic [12:0] task_reg_index;

  phase_t      phase, phase_next;
  logic [7:0]  saved_vector, saved_vector_next;
  logic [31:0] saved_return, saved_return_next;
  logic [15:0] saved_cs, saved_cs_next;
  logic [15:0] saved_ss, saved_ss_next;
  logic [31:0] saved_esp, saved_esp_next;
  logic [31:0] saved_flags, saved_flags_next;
  logic [31:0] handler_addr, handler_addr_next;
  logic [31:0] tss_base, tss_base_next;

  cmd_t        cmd;
  logic        start_entry;
  logic [7:0]  vec_sel;
  logic [31:0] gate_addr_new;
  logic [31:0] gate_addr_saved;
  logic [31:0] desc_addr;
  logic [31:0] tss_base_hi;

  assign cmd = cmd_t'(command);

  // Entry starts on a raise, or a poll with timer pending and IF set, while idle
  assign start_entry = (phase == PH_IDLE) &&
                       ((cmd == CMD_RAISE) ||
                        ((cmd == CMD_POLL) && timer_pending && flags[IF_BIT]));
  assign vec_sel         = (cmd == CMD_RAISE) ? vector : TIMER_VECTOR;
  assign gate_addr_new   = idt_base + {21'b0, vec_sel, 3'b0};
  assign gate_addr_saved = idt_base + {21'b0, saved_vector, 3'b0};
  assign desc_addr       = gdt_base + {16'b0, task_reg_index, 3'b0};
  assign tss_base_hi     = {read_data[31:24], read_data[7:0], tss_base[15:0]};

  // Next phase
  always_comb begin
    phase_next = phase;
    case (cmd)
      CMD_RAISE, CMD_POLL: begin
        if (start_entry) phase_next = PH_GATE_HI;
      end
      CMD_REPLY: begin
        case (phase)
          PH_GATE_HI: phase_next = read_data[PRESENT_BIT] ? PH_GATE_LO : PH_IDLE;
          PH_GATE_LO: phase_next = (saved_cs[1:0] == USER_PL) ? PH_GDT_LO : PH_IDLE;
          PH_GDT_LO:  phase_next = PH_GDT_HI;
          PH_GDT_HI:  phase_next = PH_KSP;
          default:    phase_next = PH_IDLE;
        endcase
      end
      default: phase_next = phase;
    endcase
  end

  // Burst descriptor and context updates
  always_comb begin
    burst = '{seq: 1'b0, start: ST_PUSH_FLAGS, kind: KIND_IGNORE, addr: 32'd0, sp: 32'd0};
    saved_vector_next = saved_vector;
    saved_return_next = saved_return;
    saved_cs_next     = saved_cs;
    saved_ss_next     = saved_ss;
    saved_esp_next    = saved_esp;
    saved_flags_next  = saved_flags;
    handler_addr_next = handler_addr;
    tss_base_next     = tss_base;
    case (cmd)
      CMD_RAISE, CMD_POLL: begin
        if (start_entry) begin
          saved_vector_next = vec_sel;
          saved_return_next = return_addr;
          saved_cs_next     = code_seg;
          saved_ss_next     = stack_seg;
          saved_esp_next    = stack_ptr;
          saved_flags_next  = flags;
          burst.kind        = KIND_READ;
          burst.addr        = gate_addr_new + DWORD_BYTES;
        end
      end
      CMD_REPLY: begin
        case (phase)
          PH_GATE_HI: begin
            if (read_data[PRESENT_BIT]) begin
              handler_addr_next = {read_data[31:16], 16'b0};
              burst.kind        = KIND_READ;
              burst.addr        = gate_addr_saved;
            end
          end
          PH_GATE_LO: begin
            handler_addr_next = {handler_addr[31:16], read_data[15:0]};
            if (saved_cs[1:0] == USER_PL) begin
              burst.kind = KIND_READ;
              burst.addr = desc_addr;
            end else begin
              burst.seq   = 1'b1;
              burst.start = ST_PUSH_FLAGS;
              burst.sp    = saved_esp;
            end
          end
          PH_GDT_LO: begin
            tss_base_next = {16'b0, read_data[31:16]};
            burst.kind    = KIND_READ;
            burst.addr    = desc_addr + DWORD_BYTES;
          end
          PH_GDT_HI: begin
            tss_base_next = tss_base_hi;
            burst.kind    = KIND_READ;
            burst.addr    = tss_base_hi + DWORD_BYTES;
          end
          PH_KSP: begin
            burst.seq   = 1'b1;
            burst.start = ST_PUSH_SS;
            burst.sp    = (read_data != 32'd0) ? read_data : saved_esp;
          end
          default: begin
            burst.kind = KIND_IGNORE;
          end
        endcase
      end
      default: begin
        burst.kind = KIND_IGNORE;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idt_base       <= 32'd0;
      gdt_base       <= 32'd0;
      task_reg_index <= 13'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IDT_BASE: idt_base       <= cfg_data;
        REG_GDT_BASE: gdt_base       <= cfg_data;
        REG_TASK_IDX: task_reg_index <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Advance phase and context on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      saved_vector <= 8'd0;
      saved_return <= 32'd0;
      saved_cs     <= 16'd0;
      saved_ss     <= 16'd0;
      saved_esp    <= 32'd0;
      saved_flags  <= 32'd0;
      handler_addr <= 32'd0;
      tss_base     <= 32'd0;
    end else if (accept) begin
      phase        <= phase_next;
      saved_vector <= saved_vector_next;
      saved_return <= saved_return_next;
      saved_cs     <= saved_cs_next;
      saved_ss     <= saved_ss_next;
      saved_esp    <= saved_esp_next;
      saved_flags  <= saved_flags_next;
      handler_addr <= handler_addr_next;
      tss_base     <= tss_base_next;
    end
  end

  assign ctx = '{ss: saved_ss, esp: saved_esp, flags: saved_flags, cs: saved_cs,
                 ret: saved_return, handler: handler_addr, tss: tss_base};

endmodule

@@ hdl/ies_emit.sv @@
// Result stage: holds one burst descriptor and drains its results one a cycle while res_stall is low.
// Reads saved context from ies_ctrl. Depends on ies_pkg.
module ies_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ies_pkg::burst_t     burst,
  input  ies_pkg::ctx_t       ctx,
  output logic                free,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [1:0]          kind,
  output logic [31:0]         address,
  output logic [31:0]         write_data,
  output logic [31:0]         new_pc,
  output logic [31:0]         new_stack_ptr,
  output logic [31:0]         new_flags,
  output logic                last
);
  import ies_pkg::*;

  logic        busy;
  logic        seq;
  step_t       step, step_next;
  kind_t       single_kind;
  logic [31:0] single_addr;
  logic [31:0] sp;
  logic [31:0] sp_m4;
  logic        take;
  logic        is_push;
  logic [31:0] flags_clr;

  assign sp_m4     = sp - DWORD_BYTES;
  assign res_valid = busy;
  assign last      = !seq || (step == ST_DONE);
  assign take      = busy && !res_stall;
  assign free      = !busy || (take && last);
  assign is_push   = (step != ST_CLEAR_KSP) && (step != ST_DONE);

  always_comb begin
    flags_clr         = ctx.flags;
    flags_clr[IF_BIT] = 1'b0;
  end

  // Advance through the burst
  always_comb begin
    case (step)
      ST_PUSH_SS:    step_next = ST_PUSH_ESP;
      ST_PUSH_ESP:   step_next = ST_CLEAR_KSP;
      ST_CLEAR_KSP:  step_next = ST_PUSH_FLAGS;
      ST_PUSH_FLAGS: step_next = ST_PUSH_CS;
      ST_PUSH_CS:    step_next = ST_PUSH_RET;
      default:       step_next = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (take && last) begin
      busy <= 1'b0;
    end
  end

  // Load a new burst, or step the current one as results are taken
  always_ff @(posedge clk) begin
    if (accept) begin
      seq         <= burst.seq;
      step        <= burst.start;
      single_kind <= burst.kind;
      single_addr <= burst.addr;
      sp          <= burst.sp;
    end else if (take && !last) begin
      step <= step_next;
      if (is_push) sp <= sp_m4;
    end
  end

  // Drive result fields for the current step
  always_comb begin
    kind          = KIND_IGNORE;
    address       = 32'd0;
    write_data    = 32'd0;
    new_pc        = 32'd0;
    new_stack_ptr = 32'd0;
    new_flags     = 32'd0;
    if (!seq) begin
      kind    = single_kind;
      address = (single_kind == KIND_READ) ? single_addr : 32'd0;
    end else begin
      case (step)
        ST_PUSH_SS: begin
          kind       = KIND_WRITE;
          address    = sp_m4;
          write_data = {16'b0, ctx.ss};
        end
        ST_PUSH_ESP: begin
          kind       = KIND_WRITE;
          address    = sp_m4;
          write_data = ctx.esp;
        end
        ST_CLEAR_KSP: begin
          kind    = KIND_WRITE;
          address = ctx.tss + DWORD_BYTES;
        end
        ST_PUSH_FLAGS: begin
          kind       = KIND_WRITE;
          address    = sp_m4;
          write_data = ctx.flags;
        end
        ST_PUSH_CS: begin
          kind       = KIND_WRITE;
          address    = sp_m4;
          write_data = {16'b0, ctx.cs};
        end
        ST_PUSH_RET: begin
          kind       = KIND_WRITE;
          address    = sp_m4;
          write_data = ctx.ret;
        end
        ST_DONE: begin
          kind          = KIND_DONE;
          new_pc        = ctx.handler;
          new_stack_ptr = sp;
          new_flags     = flags_clr;
        end
        default: begin
          kind = KIND_IGNORE;
        end
      endcase
    end
  end

endmodule

@@ hdl/interrupt_entry_sequencer.sv @@
// Top level of the interrupt entry sequencer.
// Instantiates ies_ctrl and ies_emit; depends on ies_pkg.
//
// Usage:
//   Command channel (cmd_valid/cmd_stall): raise, poll-timer and read-reply
//   requests with the CPU context fields. Result channel (res_valid/
//   res_stall): read and write memory requests, the entry-done report or an
//   ignore notice; last marks the final result of each request.
//   Configuration: cfg_write with cfg_index/cfg_data sets the IDT base, GDT
//   base and TSS selector index; write only while the block is idle.
//   Timing: the first result of a request is valid the cycle after it is
//   accepted. A request that yields one result can be followed by the next
//   request every cycle while no result is stalled. A reply that finishes
//   entry yields four results (kernel mode) or seven (user mode), drained
//   one per cycle by the result stage while not stalled, so the command
//   channel stalls until the last of them is taken. A stalled result holds
//   the result stage and, through it, the command channel; nothing is lost.
//   Reset (rst, synchronous): clears configuration, phase and saved context;
//   no result is pending afterward.
module interrupt_entry_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  vector,
  input  logic [31:0] return_addr,
  input  logic [15:0] code_seg,
  input  logic [15:0] stack_seg,
  input  logic [31:0] stack_ptr,
  input  logic [31:0] flags,
  input  logic        timer_pending,
  input  logic [31:0] read_data,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [31:0] address,
  output logic [31:0] write_data,
  output logic [31:0] new_pc,
  output logic [31:0] new_stack_ptr,
  output logic [31:0] new_flags,
  output logic        last
);
  import ies_pkg::*;

  burst_t burst;
  ctx_t   ctx;
  logic   free;
  logic   accept;

  assign cmd_stall = !free;
  assign accept    = cmd_valid && free;

  ies_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .command       (command),
    .vector        (vector),
    .return_addr   (return_addr),
    .code_seg      (code_seg),
    .stack_seg     (stack_seg),
    .stack_ptr     (stack_ptr),
    .flags         (flags),
    .timer_pending (timer_pending),
    .read_data     (read_data),
    .burst         (burst),
    .ctx           (ctx)
  );

  ies_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .burst         (burst),
    .ctx           (ctx),
    .free          (free),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .address       (address),
    .write_data    (write_data),
    .new_pc        (new_pc),
    .new_stack_ptr (new_stack_ptr),
    .new_flags     (new_flags),
    .last          (last)
  );

endmodule

@@ tb/ies_entry_checker.sv @@
// Checker for the interrupt entry sequencer: follows configuration writes,
// predicts the memory requests and reports each accepted request causes and
// compares every accepted result. Depends on ies_pkg for the codes.
module ies_entry_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  vector,
  input  logic [31:0] return_addr,
  input  logic [15:0] code_seg,
  input  logic [15:0] stack_seg,
  input  logic [31:0] stack_ptr,
  input  logic [31:0] flags,
  input  logic        timer_pending,
  input  logic [31:0] read_data,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [31:0] new_pc,
  input  logic [31:0] new_stack_ptr,
  input  logic [31:0] new_flags,
  input  logic        last,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ies_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] new_pc;
    logic [31:0] new_stack_ptr;
    logic [31:0] new_flags;
    logic        last;
  } mem_result_t;

  mem_result_t expected_results[$];
  mem_result_t burst[7];
  mem_result_t oldest;
  int          burst_len;
  int          mismatches = 0;

  // Shadow configuration
  logic [31:0] idt_base_q;
  logic [31:0] gdt_base_q;
  logic [12:0] task_idx_q;

  // Shadow sequence state and captured context
  phase_t      entry_phase;
  logic [7:0]  ctx_vector;
  logic [31:0] ctx_return;
  logic [15:0] ctx_cs;
  logic [15:0] ctx_ss;
  logic [31:0] ctx_esp;
  logic [31:0] ctx_flags;
  logic [31:0] handler_q;
  logic [31:0] tss_base_q;
  logic [31:0] entry_sp;

  assign fail_count = mismatches;

  function automatic void emit(input kind_t k, input logic [31:0] addr, data, pc, sp, fl);
    burst[burst_len] = '{kind: k, address: addr, write_data: data, new_pc: pc,
                         new_stack_ptr: sp, new_flags: fl, last: 1'b0};
    burst_len++;
  endfunction

  function automatic logic [31:0] gate_addr();
    return idt_base_q + {21'b0, ctx_vector, 3'b0};
  endfunction

  function automatic logic [31:0] desc_addr();
    return gdt_base_q + {16'b0, task_idx_q, 3'b0};
  endfunction

  // Decrement the stack pointer, then store one dword there
  function automatic void push_dword(input logic [31:0] val);
    entry_sp = entry_sp - DWORD_BYTES;
    emit(KIND_WRITE, entry_sp, val, '0, '0, '0);
  endfunction

  // Push the return frame and report the handler
  function automatic void finish_entry();
    push_dword(ctx_flags);
    push_dword({16'b0, ctx_cs});
    push_dword(ctx_return);
    emit(KIND_DONE, '0, '0, handler_q, entry_sp, ctx_flags & ~(32'd1 << IF_BIT));
    entry_phase = PH_IDLE;
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void predict_request(input logic [1:0] cmd, input logic [7:0] vec,
                                          input logic [31:0] ret, input logic [15:0] cs, ss,
                                          input logic [31:0] esp, fl, input logic timer,
                                          input logic [31:0] data);
    burst_len = 0;
    case (cmd)
      CMD_RAISE, CMD_POLL: begin
        if (entry_phase == PH_IDLE && (cmd == CMD_RAISE || (timer && fl[IF_BIT]))) begin
          ctx_vector = (cmd == CMD_RAISE) ? vec : TIMER_VECTOR;
          ctx_return = ret;
          ctx_cs     = cs;
          ctx_ss     = ss;
          ctx_esp    = esp;
          ctx_flags  = fl;
          emit(KIND_READ, gate_addr() + DWORD_BYTES, '0, '0, '0, '0);
          entry_phase = PH_GATE_HI;
        end else begin
          emit(KIND_IGNORE, '0, '0, '0, '0, '0);
        end
      end
      CMD_REPLY: begin
        case (entry_phase)
          PH_GATE_HI: begin
            if (!data[PRESENT_BIT]) begin
              emit(KIND_IGNORE, '0, '0, '0, '0, '0);
              entry_phase = PH_IDLE;
            end else begin
              handler_q = {data[31:16], 16'b0};
              emit(KIND_READ, gate_addr(), '0, '0, '0, '0);
              entry_phase = PH_GATE_LO;
            end
          end
          PH_GATE_LO: begin
            handler_q[15:0] = data[15:0];
            if (ctx_cs[1:0] == USER_PL) begin
              emit(KIND_READ, desc_addr(), '0, '0, '0, '0);
              entry_phase = PH_GDT_LO;
            end else begin
              entry_sp = ctx_esp;
              finish_entry();
            end
          end
          PH_GDT_LO: begin
            tss_base_q = {16'b0, data[31:16]};
            emit(KIND_READ, desc_addr() + DWORD_BYTES, '0, '0, '0, '0);
            entry_phase = PH_GDT_HI;
          end
          PH_GDT_HI: begin
            tss_base_q = {data[31:24], data[7:0], tss_base_q[15:0]};
            emit(KIND_READ, tss_base_q + DWORD_BYTES, '0, '0, '0, '0);
            entry_phase = PH_KSP;
          end
          PH_KSP: begin
            // Switch to the kernel stack unless the saved pointer is zero
            entry_sp = (data != '0) ? data : ctx_esp;
            push_dword({16'b0, ctx_ss});
            push_dword(ctx_esp);
            emit(KIND_WRITE, tss_base_q + DWORD_BYTES, '0, '0, '0, '0);
            finish_entry();
          end
          default: begin
            emit(KIND_IGNORE, '0, '0, '0, '0, '0);
            entry_phase = PH_IDLE;
          end
        endcase
      end
      default: emit(KIND_IGNORE, '0, '0, '0, '0, '0);
    endcase
    burst[burst_len-1].last = 1'b1;
    for (int i = 0; i < burst_len; i++) expected_results.push_back(burst[i]);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Track configuration, compare results, then predict new requests
  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      idt_base_q  = '0;
      gdt_base_q  = '0;
      task_idx_q  = '0;
      entry_phase = PH_IDLE;
      ctx_vector  = '0;
      ctx_return  = '0;
      ctx_cs      = '0;
      ctx_ss      = '0;
      ctx_esp     = '0;
      ctx_flags   = '0;
      handler_q   = '0;
      tss_base_q  = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IDT_BASE: idt_base_q = cfg_data;
          REG_GDT_BASE: gdt_base_q = cfg_data;
          REG_TASK_IDX: task_idx_q = cfg_data[12:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual kind %0d address %h",
                   $time, kind, address);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", {30'b0, oldest.kind}, {30'b0, kind});
          check_field("address", oldest.address, address);
          check_field("write_data", oldest.write_data, write_data);
          check_field("new_pc", oldest.new_pc, new_pc);
          check_field("new_stack_ptr", oldest.new_stack_ptr, new_stack_ptr);
          check_field("new_flags", oldest.new_flags, new_flags);
          check_field("last", {31'b0, oldest.last}, {31'b0, last});
        end
      end
      if (cmd_valid && !cmd_stall) begin
        predict_request(command, vector, return_addr, code_seg, stack_seg, stack_ptr,
                        flags, timer_pending, read_data);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/interrupt_entry_sequencer_test.sv @@
// Top of the interrupt entry sequencer testbench: clock, reset, request and
// result channel drivers and the verdict. Depends on ies_pkg, the block and
// ies_entry_checker, which predicts and compares.
module interrupt_entry_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ies_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 90;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        cmd_valid;
  logic        cmd_stall;
  logic [1:0]  command;
  logic [7:0]  vector;
  logic [31:0] return_addr;
  logic [15:0] code_seg;
  logic [15:0] stack_seg;
  logic [31:0] stack_ptr;
  logic [31:0] flags;
  logic        timer_pending;
  logic [31:0] read_data;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] write_data;
  logic [31:0] new_pc;
  logic [31:0] new_stack_ptr;
  logic [31:0] new_flags;
  logic        last;
  int          fail_count;
  int          outstanding;

  bit          no_idle = 1'b0;
  int          sent_requests = 0;
  int          hold_cycles = 0;
  int          hold_draw;
  int          quiet_cycles = 0;

  interrupt_entry_sequencer dut (.*);

  ies_entry_checker entry_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hold off results for a random number of cycles after each one, unless no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      res_stall   <= 1'b0;
      hold_cycles <= 0;
    end else if (res_valid && !res_stall) begin
      hold_draw = no_idle ? 0 : $urandom_range(0, 7);
      res_stall   <= (hold_draw != 0);
      hold_cycles <= hold_draw;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_cycles == 1) begin
      hold_cycles <= 0;
      res_stall   <= 1'b0;
    end
  end

  // Drop the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic configure(input logic [31:0] idt, gdt, input logic [12:0] tidx);
    cfg_write <= 1'b1;
    cfg_index <= REG_IDT_BASE;
    cfg_data  <= idt;
    @(posedge clk);
    cfg_index <= REG_GDT_BASE;
    cfg_data  <= gdt;
    @(posedge clk);
    cfg_index <= REG_TASK_IDX;
    cfg_data  <= {19'b0, tidx};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] vec,
                              input logic [31:0] ret, input logic [15:0] cs, ss,
                              input logic [31:0] esp, fl, input logic timer,
                              input logic [31:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid     <= 1'b1;
    command       <= cmd;
    vector        <= vec;
    return_addr   <= ret;
    code_seg      <= cs;
    stack_seg     <= ss;
    stack_ptr     <= esp;
    flags         <= fl;
    timer_pending <= timer;
    read_data     <= data;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent_requests++;
  endtask

  task automatic send_reply(input logic [31:0] data);
    send_request(CMD_REPLY, 8'($urandom), $urandom, 16'($urandom), 16'($urandom),
                 $urandom, $urandom, 1'($urandom), data);
  endtask

  // Occasionally slip in a command the busy block must ignore
  task automatic busy_noise();
    logic [1:0] code;
    code = 2'($urandom_range(0, 2));
    if (code == CMD_REPLY) code = CMD_NONE;
    if ($urandom_range(0, 5) == 0) begin
      send_request(code, 8'($urandom), $urandom, 16'($urandom), 16'($urandom),
                   $urandom, $urandom, 1'($urandom), $urandom);
    end
  endtask

  // Requests that leave an idle block idle
  task automatic idle_noise();
    logic [31:0] fl;
    logic        timer;
    int          pick;
    pick  = $urandom_range(0, 2);
    fl    = $urandom;
    timer = 1'($urandom);
    case (pick)
      0: send_reply($urandom);
      1: send_request(CMD_NONE, 8'($urandom), $urandom, 16'($urandom), 16'($urandom),
                      $urandom, fl, timer, $urandom);
      default: begin
        if (timer) fl[IF_BIT] = 1'b0;
        send_request(CMD_POLL, 8'($urandom), $urandom, 16'($urandom), 16'($urandom),
                     $urandom, fl, timer, $urandom);
      end
    endcase
  endtask

  // One entry with random context and the replies it asks for; the gate is sometimes absent
  task automatic run_entry();
    logic        use_poll;
    logic        user;
    logic [15:0] cs;
    logic [31:0] fl;
    logic [31:0] gate_hi;
    logic [31:0] ksp;
    use_poll = ($urandom_range(0, 3) == 0);
    user     = 1'($urandom);
    cs       = 16'($urandom);
    cs[1:0]  = user ? USER_PL : 2'($urandom_range(0, 2));
    fl       = $urandom;
    if (use_poll) fl[IF_BIT] = 1'b1;
    send_request(use_poll ? CMD_POLL : CMD_RAISE, 8'($urandom), $urandom, cs,
                 16'($urandom), $urandom, fl, use_poll ? 1'b1 : 1'($urandom), $urandom);
    busy_noise();
    gate_hi = $urandom;
    gate_hi[PRESENT_BIT] = ($urandom_range(0, 9) != 0);
    send_reply(gate_hi);
    if (gate_hi[PRESENT_BIT]) begin
      busy_noise();
      send_reply($urandom);
      if (user) begin
        busy_noise();
        send_reply($urandom);
        busy_noise();
        send_reply($urandom);
        ksp = ($urandom_range(0, 4) == 0) ? '0 : $urandom;
        busy_noise();
        send_reply(ksp);
      end
    end
  endtask

  // Drop valid and wait for every expected result, then let the block settle
  task automatic wait_drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_idx;
    int phase_end;
    int pick;
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_IDT_BASE;
    cfg_data      <= '0;
    cmd_valid     <= 1'b0;
    command       <= CMD_NONE;
    vector        <= '0;
    return_addr   <= '0;
    code_seg      <= '0;
    stack_seg     <= '0;
    stack_ptr     <= '0;
    flags         <= '0;
    timer_pending <= 1'b0;
    read_data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: wrapping table bases and the largest task index
    configure(32'hffff_fff8, 32'hffff_fff0, 13'h1fff);
    // reply while idle, command code three, polls without an interrupt
    send_request(CMD_REPLY, 8'hff, '1, '1, '1, '1, '1, 1'b1, '1);
    send_request(CMD_NONE, 8'h00, '0, '0, '0, '0, '0, 1'b0, '0);
    send_request(CMD_POLL, 8'h00, '0, '0, '0, '0, 32'h0000_0200, 1'b0, '0);
    send_request(CMD_POLL, 8'hff, '1, '1, '1, '1, 32'hffff_fdff, 1'b1, '1);
    // kernel entry with stack wrap and commands while busy
    send_request(CMD_RAISE, 8'hff, '1, 16'hfffc, '1, '0, '1, 1'b0, '0);
    send_request(CMD_RAISE, 8'h10, '0, '0, '0, '0, '0, 1'b0, '0);
    send_request(CMD_POLL, 8'h00, '0, '0, '0, '0, 32'h0000_0200, 1'b1, '0);
    send_reply('1);
    send_reply('0);
    // gate absent
    send_request(CMD_RAISE, 8'h00, 32'h1234_5678, 16'h0008, 16'h0010, 32'h0000_1000,
                 32'h0000_0202, 1'b0, '0);
    send_reply(32'hffff_7fff);
    // timer entry from user mode with a zero kernel stack pointer
    send_request(CMD_POLL, 8'h55, 32'h0804_8000, 16'hffff, 16'hffff, 32'hbfff_fff0,
                 32'h0000_0246, 1'b1, '0);
    send_reply(32'h0000_8e00);
    send_reply(32'hc000_1000);
    send_reply(32'hffff_0067);
    send_reply(32'h0000_0000);
    send_reply(32'h0000_0000);
    // user entry switching to a kernel stack that wraps
    send_request(CMD_RAISE, 8'h01, '0, 16'h001b, 16'h0023, 32'h0040_0000, '1, 1'b1, '1);
    send_reply(32'h0000_8000);
    send_reply(32'hffff_ffff);
    send_reply(32'h0000_ffff);
    send_reply(32'hff00_00ff);
    send_reply(32'h0000_0002);
    wait_drain();

    // Random phases, each under its own configuration
    for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
      case (phase_idx)
        0: configure('0, '0, '0);
        1: configure('1, '1, 13'h1fff);
        2: configure($urandom, $urandom, 13'($urandom));
        default: configure($urandom, $urandom, 13'($urandom_range(0, 15)));
      endcase
      no_idle   = (phase_idx == 2);
      phase_end = sent_requests + PHASE_ITEMS;
      while (sent_requests < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) run_entry();
        else if (pick < 19) idle_noise();
        else wait_drain();
      end
      wait_drain();
    end
    no_idle = 1'b0;

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
